// File: src/codebook_nearest_block_match_unit_defines.svh
// Assertion macros shared by the codebook block matcher.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef CODEBOOK_NEAREST_BLOCK_MATCH_UNIT_DEFINES_SVH
`define CODEBOOK_NEAREST_BLOCK_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CNBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNBM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cnbm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the pixel compression function of the block matcher.
// Depends on nothing.
package cnbm_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_PIX    = 9;
    localparam int CHAR_W     = 21;
    localparam int DIST_W     = 12;
    localparam int SIZE_W     = 9;
    localparam int FLOOR_W    = 8;
    localparam int SLOT_W     = 8;
    localparam int OUT_IDX_W  = 8;
    localparam int PAT_W      = NUM_PIX * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 9;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0] t_absvec;

    // Control that travels alongside one codebook read through the pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_ctl;

    // p*(255-floor)/255 + floor. The division by 255 uses the exact identity
    // x/255 = (x + 1 + (x >> 8)) >> 8, which holds for every 16-bit product here.
    function automatic logic [PIX_W-1:0] compress(input logic [PIX_W-1:0] p,
                                                  input logic [FLOOR_W-1:0] fl);
        logic [2*PIX_W-1:0] prod;
        logic [2*PIX_W-1:0] q;
        prod = p * (FULL_SCALE - fl);
        q = (prod + 16'd1 + (prod >> 8)) >> 8;
        return q[PIX_W-1:0] + fl;
    endfunction

endpackage

// File: src/cnbm_lane.sv
`timescale 1ns / 1ps
// One pixel lane: holds the compressed input pixel of a match and forms its
// absolute difference to the codebook pixel read each cycle. Uses cnbm_pkg.
module cnbm_lane (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [cnbm_pkg::PIX_W-1:0] i_pixel,
    input  logic [cnbm_pkg::FLOOR_W-1:0] i_floor,
    input  logic [cnbm_pkg::PIX_W-1:0] i_pat,
    output logic [cnbm_pkg::PIX_W-1:0] o_absdiff
);

    logic [cnbm_pkg::PIX_W-1:0] r_pix;
    logic [cnbm_pkg::PIX_W-1:0] r_abs;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= cnbm_pkg::compress(i_pixel, i_floor);
        end
        r_abs <= (r_pix > i_pat) ? (r_pix - i_pat) : (i_pat - r_pix);
    end

    assign o_absdiff = r_abs;

endmodule

// File: src/cnbm_merge.sv
`timescale 1ns / 1ps
// Merging stage: sums the lane differences, then keeps the running minimum
// with its index and code point. Uses cnbm_pkg.
module cnbm_merge #(
    parameter int IDX_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cnbm_pkg::t_ctl               i_ctl,
    input  cnbm_pkg::t_absvec            i_abs,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [cnbm_pkg::CHAR_W-1:0]  i_char,
    output logic                         o_done,
    output logic [IDX_W-1:0]             o_best_idx,
    output logic [cnbm_pkg::CHAR_W-1:0]  o_best_char,
    output logic [cnbm_pkg::DIST_W-1:0]  o_best_dist
);

    cnbm_pkg::t_ctl                r_s3_ctl;
    logic [cnbm_pkg::DIST_W-1:0]   r_s3_sum;
    logic [IDX_W-1:0]              r_s3_idx;
    logic [cnbm_pkg::CHAR_W-1:0]   r_s3_char;
    logic [IDX_W-1:0]              r_best_idx;
    logic [cnbm_pkg::CHAR_W-1:0]   r_best_char;
    logic [cnbm_pkg::DIST_W-1:0]   r_best_dist;
    logic                          r_done;
    logic [cnbm_pkg::DIST_W-1:0]   n_sum;
    logic                          n_take;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < cnbm_pkg::NUM_PIX; k++) begin
            n_sum = n_sum + cnbm_pkg::DIST_W'(i_abs[k]);
        end
    end

    // The first entry always wins; later ones only when strictly closer.
    assign n_take = r_s3_ctl.valid && (r_s3_ctl.first || (r_s3_sum < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
            r_done   <= 1'b0;
        end else begin
            r_s3_ctl <= i_ctl;
            r_done   <= r_s3_ctl.valid && r_s3_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_sum  <= n_sum;
        r_s3_idx  <= i_idx;
        r_s3_char <= i_char;
        if (n_take) begin
            r_best_idx  <= r_s3_idx;
            r_best_char <= r_s3_char;
            r_best_dist <= r_s3_sum;
        end
    end

    assign o_done      = r_done;
    assign o_best_idx  = r_best_idx;
    assign o_best_char = r_best_char;
    assign o_best_dist = r_best_dist;

endmodule

// File: src/codebook_nearest_block_match_unit.sv
`timescale 1ns / 1ps
// Top level of the codebook block matcher: stream ports, configuration,
// codebook memories, sequencer and output register. Uses cnbm_pkg, cnbm_lane,
// cnbm_merge and the assertion macros header.
//
//   Channel    Dir   Handshake                         Content
//   s_axis     in    i_s_axis_tvalid/o_s_axis_tready   write entry or match block
//   m_axis     out   o_m_axis_tvalid/i_m_axis_tready   nearest entry of a match
//   cfg        in    i_cfg_we                          codebook_size, luma_floor
//
// A write transfer stores one codebook entry and the block is ready again at
// once. A match sweeps n entries, n being the searched entry count clamped to
// 1..MAX_ENTRIES; no new transfer is taken until its result has entered the
// output register. The pattern memory has one read port and yields one entry
// per cycle, which the nine lanes compare in parallel. Reset is synchronous
// and active low; it clears the configuration, control state and valid flags
// but not the datapath or the codebook, whose entries are meaningful only once
// written. A stalled output holds its result while a new transfer may still be
// taken; a second result then waits inside the block and holds the input off.
`include "codebook_nearest_block_match_unit_defines.svh"
module codebook_nearest_block_match_unit #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, from bit 0: entry_index[7:0], pixel_0..pixel_8 (8 bits each),
    // char_code[20:0], zero padding
    input  logic [cnbm_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: req_type (0 writes an entry, 1 matches a block)
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, from bit 0: best_index[7:0], best_char[20:0], best_distance[11:0],
    // zero padding
    output logic [cnbm_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [cnbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cnbm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SZ_W   = (CNT_W > cnbm_pkg::SIZE_W) ? CNT_W : cnbm_pkg::SIZE_W;
    localparam int SLW_W  = (CNT_W > cnbm_pkg::SLOT_W) ? CNT_W : cnbm_pkg::SLOT_W;
    localparam int OIW_W  = (IDX_W > cnbm_pkg::OUT_IDX_W) ? IDX_W : cnbm_pkg::OUT_IDX_W;
    localparam int PAD_W  = cnbm_pkg::OUT_DATA_W - cnbm_pkg::OUT_IDX_W
                            - cnbm_pkg::CHAR_W - cnbm_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // Input payload fields.
    logic                             s_acc;
    logic [cnbm_pkg::SLOT_W-1:0]      s_slot;
    logic [cnbm_pkg::PAT_W-1:0]       s_pat;
    logic [cnbm_pkg::CHAR_W-1:0]      s_char;

    // Configuration.
    logic [cnbm_pkg::SIZE_W-1:0]      r_size;
    logic [cnbm_pkg::FLOOR_W-1:0]     r_floor;

    // Codebook memories.
    logic [cnbm_pkg::PAT_W-1:0]       pat_mem [MAX_ENTRIES];
    logic [cnbm_pkg::CHAR_W-1:0]      char_mem [MAX_ENTRIES];
    logic [cnbm_pkg::PAT_W-1:0]       r_rd_pat;
    logic [cnbm_pkg::CHAR_W-1:0]      r_rd_char;
    logic [SLW_W-1:0]                 slot_wide;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [IDX_W-1:0]                 rd_addr;

    // Sequencer.
    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [CNT_W-1:0]                 r_cnt;
    logic [CNT_W-1:0]                 n_cnt;
    logic [CNT_W-1:0]                 r_n;
    logic [SZ_W-1:0]                  size_wide;
    logic [SZ_W-1:0]                  n_eff;
    logic                             issue_last;

    // Pipeline side-band.
    cnbm_pkg::t_ctl                   r_s1_ctl;
    cnbm_pkg::t_ctl                   r_s2_ctl;
    logic [IDX_W-1:0]                 r_s1_idx;
    logic [IDX_W-1:0]                 r_s2_idx;
    logic [cnbm_pkg::CHAR_W-1:0]      r_s2_char;
    cnbm_pkg::t_absvec                lane_abs;
    logic                             lane_load;

    // Merge results and output register.
    logic                             merge_done;
    logic [IDX_W-1:0]                 best_idx;
    logic [cnbm_pkg::CHAR_W-1:0]      best_char;
    logic [cnbm_pkg::DIST_W-1:0]      best_dist;
    logic [OIW_W-1:0]                 best_idx_wide;
    logic                             r_pend;
    logic                             out_load;
    logic                             r_out_valid;
    logic [cnbm_pkg::OUT_DATA_W-1:0]  r_out_data;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_slot = i_s_axis_tdata[cnbm_pkg::SLOT_W-1:0];
    assign s_pat  = i_s_axis_tdata[cnbm_pkg::SLOT_W +: cnbm_pkg::PAT_W];
    assign s_char = i_s_axis_tdata[cnbm_pkg::SLOT_W + cnbm_pkg::PAT_W +: cnbm_pkg::CHAR_W];

    // Input is taken only between matches; write transfers never leave idle.
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // ------------------------------------------------------------------
    // Configuration registers. Unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= cnbm_pkg::SIZE_W'(1);
            r_floor <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cnbm_pkg::REG_SIZE: begin
                    r_size <= i_cfg_data[cnbm_pkg::SIZE_W-1:0];
                end
                cnbm_pkg::REG_FLOOR: begin
                    r_floor <= i_cfg_data[cnbm_pkg::FLOOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Codebook memories: one write port driven by write transfers, one
    // registered read port swept by the sequencer. Slots beyond the
    // codebook depth are dropped.
    // ------------------------------------------------------------------
    assign slot_wide = SLW_W'(s_slot);
    assign wr_en     = s_acc && (i_s_axis_tuser == cnbm_pkg::REQ_WRITE)
                       && (slot_wide < SLW_W'(MAX_ENTRIES));
    assign wr_addr   = slot_wide[IDX_W-1:0];
    assign rd_addr   = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            pat_mem[wr_addr]  <= s_pat;
            char_mem[wr_addr] <= s_char;
        end
        r_rd_pat  <= pat_mem[rd_addr];
        r_rd_char <= char_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer. A size of zero searches one entry; sizes above the depth
    // are clamped to the depth.
    // ------------------------------------------------------------------
    assign size_wide  = SZ_W'(r_size);
    assign n_eff      = (size_wide == '0) ? SZ_W'(1)
                      : (size_wide > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES) : size_wide;
    assign issue_last = (r_cnt == r_n - CNT_W'(1));
    assign lane_load  = s_acc && (i_s_axis_tuser == cnbm_pkg::REQ_MATCH);

    // The result moves to the output register as soon as that register is
    // free or being emptied in the same cycle.
    assign out_load = (merge_done || r_pend) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (lane_load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (issue_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_n      <= CNT_W'(1);
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            if (lane_load) begin
                r_n <= n_eff[CNT_W-1:0];
            end
            r_s1_ctl.valid <= (r_state == ST_RUN);
            r_s1_ctl.first <= (r_cnt == '0);
            r_s1_ctl.last  <= issue_last;
            r_s2_ctl       <= r_s1_ctl;
            r_pend         <= (merge_done || r_pend) && !out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= rd_addr;
        r_s2_idx  <= r_s1_idx;
        r_s2_char <= r_rd_char;
    end

    // ------------------------------------------------------------------
    // Nine pixel lanes, one per position of the 3x3 block.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < cnbm_pkg::NUM_PIX; k++) begin : g_lane
        cnbm_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (lane_load),
            .i_pixel   (s_pat[k*cnbm_pkg::PIX_W +: cnbm_pkg::PIX_W]),
            .i_floor   (r_floor),
            .i_pat     (r_rd_pat[k*cnbm_pkg::PIX_W +: cnbm_pkg::PIX_W]),
            .o_absdiff (lane_abs[k])
        );
    end

    cnbm_merge #(
        .IDX_W (IDX_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s2_ctl),
        .i_abs       (lane_abs),
        .i_idx       (r_s2_idx),
        .i_char      (r_s2_char),
        .o_done      (merge_done),
        .o_best_idx  (best_idx),
        .o_best_char (best_char),
        .o_best_dist (best_dist)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    assign best_idx_wide = OIW_W'(best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, best_dist, best_char,
                           best_idx_wide[cnbm_pkg::OUT_IDX_W-1:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CNBM_ASSERT_IMP(a_done_in_wait, merge_done, r_state == ST_WAIT, "search ended outside wait")
    `CNBM_ASSERT_IMP(a_pend_single, r_pend, (r_state == ST_WAIT) && !merge_done, "bad pending")
    `CNBM_ASSERT_IMP(a_cnt_range, r_state == ST_RUN, r_cnt < r_n, "read counter overrun")
    `CNBM_ASSERT_IMP(a_out_source, $rose(r_out_valid), $past(merge_done || r_pend), "stray output")
    `CNBM_ASSERT_NXT(a_match_starts, lane_load, r_state == ST_RUN, "match did not start")

endmodule

// File: test/codebook_nearest_block_match_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the codebook nearest block matcher.
// Depends on cnbm_pkg and codebook_nearest_block_match_unit; needs nothing else.
module codebook_nearest_block_match_unit_tb;
    import cnbm_pkg::*;

    localparam int ENTRIES = 256;
    // A match searches at most ENTRIES rows and then still has to pass the pipeline.
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    // Register indexes beyond the two real registers; writes to them must do nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0] t_block;

    // One match result, laid out exactly as the low bits of the output tdata.
    typedef struct packed {
        logic [DIST_W-1:0]    sad;
        logic [CHAR_W-1:0]    code;
        logic [OUT_IDX_W-1:0] idx;
    } t_match;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // tdata, from bit 0: entry_index, pixel_0..pixel_8, char_code, zero padding
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // tuser: req_type
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // tdata, from bit 0: best_index, best_char, best_distance, zero padding
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // Our own copy of the codebook and of the two registers, at their reset values.
    t_block            pattern_mem [ENTRIES];
    logic [CHAR_W-1:0] glyph_mem [ENTRIES];
    logic [SIZE_W-1:0] cur_size = 9'd1;
    logic [7:0]        cur_floor = 8'd0;

    // Results that the block still owes us, oldest first.
    t_match pending_matches [$];

    int n_errors = 0;
    int n_writes = 0;
    int n_matches = 0;
    int n_settings = 0;

    // Random idling on either side, and a receiver hold-off counted down by the sink.
    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int hold_left = 0;

    codebook_nearest_block_match_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Number of entries a match looks at: zero still means one, and anything
    // beyond the codebook depth saturates.
    function automatic int searched_count();
        if (cur_size == 0) begin
            return 1;
        end
        if (cur_size > ENTRIES) begin
            return ENTRIES;
        end
        return int'(cur_size);
    endfunction

    // Compress a raw pixel into floor..255, truncating the division.
    function automatic logic [7:0] squeeze(input logic [7:0] p);
        int v;
        v = (int'(p) * (255 - int'(cur_floor))) / 255 + int'(cur_floor);
        return v[7:0];
    endfunction

    // Nearest codebook entry by sum of absolute differences; the strict
    // comparison keeps the lowest index when two entries tie.
    function automatic t_match nearest_entry(input t_block raw);
        t_block sq;
        int     n;
        int     d;
        int     best_d;
        int     best_i;
        t_match res;
        for (int k = 0; k < NUM_PIX; k++) begin
            sq[k] = squeeze(raw[k]);
        end
        n = searched_count();
        best_d = 0;
        best_i = 0;
        for (int i = 0; i < n; i++) begin
            d = 0;
            for (int k = 0; k < NUM_PIX; k++) begin
                d += (sq[k] > pattern_mem[i][k]) ? int'(sq[k]) - int'(pattern_mem[i][k])
                                                 : int'(pattern_mem[i][k]) - int'(sq[k]);
            end
            if (i == 0 || d < best_d) begin
                best_d = d;
                best_i = i;
            end
        end
        res.idx  = best_i[OUT_IDX_W-1:0];
        res.code = glyph_mem[best_i];
        res.sad  = best_d[DIST_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // A coarse pattern draws every pixel from black, mid grey and white, which
    // makes exact hits and ties far more likely than full-range noise does.
    function automatic t_block random_pattern(input bit coarse);
        t_block b;
        for (int k = 0; k < NUM_PIX; k++) begin
            if (coarse) begin
                case ($urandom_range(2))
                    0:       b[k] = 8'h00;
                    1:       b[k] = 8'h80;
                    default: b[k] = 8'hFF;
                endcase
            end else begin
                b[k] = PIX_W'($urandom_range(255));
            end
        end
        return b;
    endfunction

    // Raw block that compresses to (or close to) a stored pattern. Each pixel is
    // put through the inverse of the compression, and now and then nudged a few
    // steps so that small but non-zero distances turn up as well.
    function automatic t_block near_block(input int slot);
        t_block b;
        int     p;
        int     fl;
        int     v;
        fl = int'(cur_floor);
        for (int k = 0; k < NUM_PIX; k++) begin
            p = int'(pattern_mem[slot][k]);
            if (fl == 255 || p <= fl) begin
                v = 0;
            end else begin
                v = ((p - fl) * 255 + (254 - fl)) / (255 - fl);
            end
            if ($urandom_range(3) == 0) begin
                v += int'($urandom_range(6)) - 3;
            end
            if (v < 0) begin
                v = 0;
            end
            if (v > 255) begin
                v = 255;
            end
            b[k] = v[7:0];
        end
        return b;
    endfunction

    // Offer one item on the input stream and hold it until it is taken. The
    // item is presented at a falling edge; the transfer happens at the first
    // rising edge that sees tready high, and only then is the prediction made.
    // The task returns at that rising edge with tvalid still high, so that the
    // next item (or an explicit quiet_source) replaces it at the falling edge.
    task automatic send_item(input logic req, input logic [SLOT_W-1:0] slot,
                             input t_block pix, input logic [CHAR_W-1:0] code);
        @(negedge i_clk);
        while (src_gaps && $urandom_range(99) < 16) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = req;
        i_s_axis_tdata  = {{(IN_DATA_W - CHAR_W - PAT_W - SLOT_W){1'b0}}, code, pix, slot};
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) begin
                break;
            end
        end
        if (req == REQ_WRITE) begin
            pattern_mem[slot] = pix;
            glyph_mem[slot]   = code;
            n_writes++;
        end else begin
            pending_matches.push_back(nearest_entry(pix));
        end
    endtask

    task automatic quiet_source();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Stop offering items, let every owed result arrive, then give the block
    // the time of one full search so that nothing is still in flight.
    task automatic wait_idle();
        quiet_source();
        while (pending_matches.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_SIZE) begin
            cur_size = data;
        end else if (idx == REG_FLOOR) begin
            cur_floor = data[7:0];
        end
        n_settings++;
    endtask

    task automatic set_mode(input logic [CFG_W-1:0] size_data, input logic [CFG_W-1:0] floor_data);
        wait_idle();
        cfg_write(REG_SIZE, size_data);
        cfg_write(REG_FLOOR, floor_data);
    endtask

    // Mixed traffic for the current setting: a fifth of the items rewrite a
    // random slot, the rest are matches, half aimed close to an entry inside
    // the searched range and half plain noise. Every slot is loaded before
    // this is first used, so no match can reach an unwritten entry.
    task automatic random_phase(input int n_items);
        int unsigned pick;
        int          span;
        repeat (n_items) begin
            span = searched_count();
            pick = $urandom_range(99);
            if (pick < 20) begin
                send_item(REQ_WRITE, SLOT_W'($urandom), random_pattern($urandom_range(3) == 0),
                          CHAR_W'($urandom));
            end else if (pick < 60) begin
                send_item(REQ_MATCH, SLOT_W'($urandom), near_block($urandom_range(span - 1)),
                          CHAR_W'($urandom));
            end else begin
                send_item(REQ_MATCH, SLOT_W'($urandom), PAT_W'({$urandom, $urandom, $urandom}),
                          CHAR_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the block searches entry zero only, with no floor.
    // The two matches give the largest and the smallest possible distance.
    task automatic test_reset_values();
        send_item(REQ_WRITE, 8'd0, '0, '0);
        send_item(REQ_MATCH, 8'd0, {NUM_PIX{8'hFF}}, '0);
        send_item(REQ_MATCH, 8'hFF, '0, 21'h1FFFFF);
    endtask

    // Hand-built entries: white, two identical chequer patterns (a tie that
    // the lower index must win), a 55/AA chequer, a ramp, mid grey and one random.
    // Then searches of eight entries, size zero, floor at its top, a floor write
    // carrying a set bit 8, and writes to the unused register indexes.
    task automatic test_directed();
        send_item(REQ_WRITE, 8'd1, {NUM_PIX{8'hFF}}, 21'h1FFFFF);
        send_item(REQ_WRITE, 8'd2, 72'hFF00FF_00FF00_FF00FF, 21'h10FFFF);
        send_item(REQ_WRITE, 8'd3, 72'hFF00FF_00FF00_FF00FF, 21'h000041);
        send_item(REQ_WRITE, 8'd4, 72'h55AA55_AA55AA_55AA55, 21'h0AAAAA);
        send_item(REQ_WRITE, 8'd5, 72'h002040_6080A0_C0E0FF, 21'h155555);
        send_item(REQ_WRITE, 8'd6, {NUM_PIX{8'h80}}, 21'h002588);
        send_item(REQ_WRITE, 8'd7, random_pattern(1'b0), CHAR_W'($urandom));

        set_mode(9'd8, 9'd0);
        send_item(REQ_MATCH, 8'd0, {NUM_PIX{8'hFF}}, '0);
        send_item(REQ_MATCH, 8'd0, 72'hFF00FF_00FF00_FF00FF, '0);
        send_item(REQ_MATCH, 8'd0, '0, '0);
        send_item(REQ_MATCH, 8'd0, {NUM_PIX{8'h80}}, '0);

        set_mode(9'd0, 9'd0);
        send_item(REQ_MATCH, 8'd0, PAT_W'({$urandom, $urandom, $urandom}), '0);

        // With the floor at 255 every pixel compresses to white.
        set_mode(9'd0, 9'd255);
        send_item(REQ_MATCH, 8'd0, '0, '0);

        // Bit 8 of the data is not part of the floor, so this sets it to 200.
        set_mode(9'd8, 9'h1C8);
        send_item(REQ_MATCH, 8'd0, PAT_W'({$urandom, $urandom, $urandom}), '0);

        wait_idle();
        cfg_write(REG_SPARE_2, 9'h1FF);
        cfg_write(REG_SPARE_3, 9'h000);
        send_item(REQ_MATCH, 8'd0, 72'h002040_6080A0_C0E0FF, '0);
    endtask

    // Fill every slot. Every eighth entry repeats an earlier pattern under a
    // new random code point, so that full-range searches meet ties too.
    task automatic load_codebook();
        t_block pat;
        for (int s = 0; s < ENTRIES; s++) begin
            if (s % 8 == 7) begin
                pat = pattern_mem[s - 3];
            end else begin
                pat = random_pattern(s % 4 == 0);
            end
            send_item(REQ_WRITE, s[7:0], pat, CHAR_W'($urandom));
        end
    endtask

    // A sweep of settings. Small searches carry most of the traffic; the
    // full-depth and saturating ones get only a handful of items each.
    task automatic test_random_settings();
        set_mode(9'd4, 9'd0);      random_phase(60);
        set_mode(9'd1, 9'd0);      random_phase(40);
        set_mode(9'd16, 9'd37);    random_phase(60);
        set_mode(9'd0, 9'd128);    random_phase(30);
        set_mode(9'd64, 9'd255);   random_phase(40);
        set_mode(9'd256, 9'd0);    random_phase(15);
        set_mode(9'h1FF, 9'h164);  random_phase(12);
        set_mode(9'd8, 9'd17);     random_phase(60);
        set_mode(9'd200, 9'd3);    random_phase(15);
        set_mode(9'd2, 9'd254);    random_phase(40);
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering back to back, so the output and its spare slot fill up and
    // the block has to stall its input.
    task automatic test_back_pressure();
        set_mode(9'd4, 9'd0);
        src_gaps  = 1'b0;
        hold_left = 300;
        random_phase(30);
        src_gaps = 1'b1;
    endtask

    // The sender stops mid-phase until every owed result has come back, then
    // resumes with the same setting.
    task automatic test_drain_pause();
        set_mode(9'd12, 9'd90);
        random_phase(15);
        quiet_source();
        while (pending_matches.size() != 0) begin
            @(posedge i_clk);
        end
        random_phase(15);
    endtask

    // A long stretch with neither side idling.
    task automatic test_no_idle();
        set_mode(9'd6, 9'd0);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        random_phase(60);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver decides its tready at each falling edge: held low while a
    // hold-off is counting down, otherwise idling at random when allowed.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_axis_tready = !(sink_gaps && $urandom_range(99) < 16);
        end
    end

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Every result transfer is compared with the oldest owed result.
    always @(posedge i_clk) begin : result_monitor
        t_match got;
        t_match want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_match)-1:0];
            if (pending_matches.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got index %0d char %0h dist %0d",
                         $time, got.idx, got.code, got.sad);
            end else begin
                want = pending_matches.pop_front();
                n_matches++;
                check_field("best_index", 32'(want.idx), 32'(got.idx));
                check_field("best_char", 32'(want.code), 32'(got.code));
                check_field("best_distance", 32'(want.sad), 32'(got.sad));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_directed();
        load_codebook();
        test_random_settings();
        test_back_pressure();
        test_drain_pause();
        test_no_idle();

        quiet_source();
        while (pending_matches.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb: %0d codebook writes and %0d checked matches over %0d register writes,",
                 n_writes, n_matches, n_settings);
        $display("tb: sizes from zero to saturation, floors from 0 to 255, with stalls on both sides");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake; a correct run ends far sooner.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
